[rtl/text_console_writer_top_macros.svh]
// assertion macros used by the console engine
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw check failed");

// next-cycle implication, checked outside reset
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw check failed");

`endif

[rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

   // port widths
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int CELL_W     = 16;

   // character codes
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [BYTE_W-1:0] ATTR_DEFAULT = 8'h07;

   // blank cell: attribute in the high byte, character in the low byte
   localparam logic [CELL_W-1:0] BLANK_DEFAULT = {ATTR_DEFAULT, CH_SPACE};

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL_COPY,
      ST_SCROLL_FILL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    cell_char;
      logic [BYTE_W-1:0]    cell_attr;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
   } res_type;

endpackage

`default_nettype wire

[rtl/text_console_writer_top.sv]
// text console writer: rows x cols screen of {attribute, character} cells plus a cursor
// put, newline, return, op 3 and an out-of-range read answer from the execute state; a
// read in range answers after a registered memory read; clear and scroll after a full sweep
// a new request is taken only from the idle state, so req_stall is high while one is in flight
// reset: synchronous; cursor home, attribute 0x07, then the screen is cleared to blank
// cells in the default attribute with req_stall high
`default_nettype none

module text_console_writer_top #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [tcw_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::ROW_OUT_W-1:0]   req_read_row,
   input  wire logic [tcw_pkg::COL_OUT_W-1:0]   req_read_col,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [tcw_pkg::BYTE_W-1:0]      rsp_cell_char,
   output      logic [tcw_pkg::BYTE_W-1:0]      rsp_cell_attr,
   output      logic [tcw_pkg::ROW_OUT_W-1:0]   rsp_cursor_row,
   output      logic [tcw_pkg::COL_OUT_W-1:0]   rsp_cursor_col,
   input  wire logic                            csr_wr_en,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      csr_wr_data
);

   import tcw_pkg::*;

   // screen memory depth and address width follow the geometry
   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);

   logic              idle;
   logic              slot_free;
   logic              res_valid;
   res_type           res;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   // output register: a finished transaction waits here while the engine takes the next one
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff;

   // the engine only takes a new transaction from its idle state
   assign req_stall = !idle;

   // the output register can load when empty or when its content leaves this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = slot_free ? res_valid : rsp_valid_ff;

   tcw_engine #(
      .ROWS   (ROWS),
      .COLS   (COLS),
      .ADDR_W (ADDR_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .idle          (idle),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .slot_free     (slot_free),
      .res_valid     (res_valid),
      .res           (res),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   // one write port and one registered read port over the whole screen
   tcw_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (CELL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (slot_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_ff.cell_char;
   assign rsp_cell_attr  = rsp_ff.cell_attr;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;

endmodule

`default_nettype wire

[rtl/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/tcw_engine.sv]
`default_nettype none
`include "text_console_writer_top_macros.svh"

module tcw_engine #(
   parameter int ROWS   = 25,
   parameter int COLS   = 80,
   parameter int ADDR_W = $clog2(ROWS * COLS)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            idle,
   input  wire logic [tcw_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::ROW_OUT_W-1:0]   req_read_row,
   input  wire logic [tcw_pkg::COL_OUT_W-1:0]   req_read_col,
   input  wire logic                            csr_wr_en,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      csr_wr_data,
   input  wire logic                            slot_free,
   output      logic                            res_valid,
   output      tcw_pkg::res_type                res,
   output      logic                            mem_wr_en,
   output      logic [ADDR_W-1:0]               mem_wr_addr,
   output      logic [tcw_pkg::CELL_W-1:0]      mem_wr_data,
   output      logic                            mem_rd_en,
   output      logic [ADDR_W-1:0]               mem_rd_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0]      mem_rd_data
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLS - 1);
   localparam logic [ADDR_W-1:0] ROW_ONE   = ADDR_W'(COLS);
   localparam logic [RW-1:0]     LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0]     LAST_COL  = CW'(COLS - 1);

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [BYTE_W-1:0]      char_ff;
   logic [ROW_OUT_W-1:0]   rrow_ff;
   logic [COL_OUT_W-1:0]   rcol_ff;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [BYTE_W-1:0]      attr_ff;
   logic [ADDR_W-1:0]      sweep_ff, sweep_in;
   logic [BYTE_W-1:0]      cell_char_ff, cell_char_in;
   logic [BYTE_W-1:0]      cell_attr_ff, cell_attr_in;

   logic                   accept;
   logic                   is_nl, is_cr, row_last, col_last, need_scroll, read_ok;
   logic [ADDR_W-1:0]      cursor_addr, read_addr, copy_src;

   assign idle   = (state_ff == ST_IDLE);
   assign accept = req_valid && idle;

   assign is_nl    = (char_ff == CH_NEWLINE);
   assign is_cr    = (char_ff == CH_RETURN);
   assign row_last = (row_ff == LAST_ROW);
   assign col_last = (col_ff == LAST_COL);
   // newline on the last row, or a printable byte in the bottom-right cell
   assign need_scroll = row_last && (is_nl || (!is_cr && col_last));

   assign read_ok = (32'(rrow_ff) < 32'(ROWS)) && (32'(rcol_ff) < 32'(COLS));

   assign cursor_addr = ADDR_W'(32'(row_ff) * 32'(COLS) + 32'(col_ff));
   assign read_addr   = ADDR_W'(32'(rrow_ff) * 32'(COLS) + 32'(rcol_ff));
   assign copy_src    = ADDR_W'(32'(sweep_ff) + 32'(COLS) + 32'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_PUT: begin
                  if (need_scroll)    state_in = ST_SCROLL_COPY;
                  else if (slot_free) state_in = ST_IDLE;
                  else                state_in = ST_DONE;
               end
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ: begin
                  if (read_ok)        state_in = ST_READ;
                  else if (slot_free) state_in = ST_IDLE;
                  else                state_in = ST_DONE;
               end
               default: begin
                  state_in = slot_free ? ST_IDLE : ST_DONE;
               end
            endcase
         end
         ST_READ: state_in = ST_DONE;
         ST_SCROLL_COPY: begin
            if (sweep_ff == LAST_COPY) state_in = ST_SCROLL_FILL;
         end
         ST_SCROLL_FILL: begin
            if (sweep_ff == LAST_CELL) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (sweep_ff == LAST_CELL) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sweep_ff;
      mem_wr_data  = BLANK_DEFAULT;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = copy_src;
      res_valid    = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_wr_en = 1'b1;
            sweep_in  = sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            sweep_in = '0;
         end
         ST_EXEC: begin
            cell_char_in = '0;
            cell_attr_in = '0;
            unique case (op_ff)
               OP_PUT: begin
                  if (is_nl) begin
                     col_in = '0;
                     if (!row_last) row_in = row_ff + RW'(1);
                  end else if (is_cr) begin
                     col_in = '0;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cursor_addr;
                     mem_wr_data = {attr_ff, char_ff};
                     if (col_last) begin
                        col_in = '0;
                        if (!row_last) row_in = row_ff + RW'(1);
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end
                  if (need_scroll) begin
                     // prime the copy with the first cell of row one
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ROW_ONE;
                  end else begin
                     res_valid = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  row_in = '0;
                  col_in = '0;
               end
               OP_READ: begin
                  if (read_ok) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = read_addr;
                  end else begin
                     res_valid = 1'b1;
                  end
               end
               default: begin
                  res_valid = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            cell_char_in = mem_rd_data[BYTE_W-1:0];
            cell_attr_in = mem_rd_data[CELL_W-1:BYTE_W];
         end
         ST_SCROLL_COPY: begin
            // write cell i from the read of cell i + cols, fetch the next
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            mem_rd_en   = (sweep_ff != LAST_COPY);
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_SCROLL_FILL: begin
            mem_wr_en = 1'b1;
            sweep_in  = sweep_ff + ADDR_W'(1);
         end
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {attr_ff, CH_SPACE};
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
      endcase
   end

   assign res.cell_char  = cell_char_in;
   assign res.cell_attr  = cell_attr_in;
   assign res.cursor_row = ROW_OUT_W'(row_in);
   assign res.cursor_col = COL_OUT_W'(col_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         attr_ff  <= ATTR_DEFAULT;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         if (csr_wr_en) attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      if (accept) begin
         op_ff   <= op_type'(req_operation);
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
   end

   `TCW_ASSERT_IMP(a_cursor_in_range, clock, reset, 1'b1,
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) < 32'(COLS)))
   `TCW_ASSERT_IMP(a_result_state, clock, reset, res_valid,
      (state_ff == ST_EXEC) || (state_ff == ST_DONE))
   `TCW_ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC)
   `TCW_ASSERT_IMP(a_no_write_idle, clock, reset,
      (state_ff == ST_IDLE) || (state_ff == ST_DONE) || (state_ff == ST_READ), !mem_wr_en)

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

   import tcw_pkg::*;

   localparam int ROWS          = 25;
   localparam int COLS          = 80;
   localparam int CELL_COUNT    = ROWS * COLS;
   localparam int CYCLE_LIMIT   = 1_200_000;
   // console sweeps (scroll or clear) each cost a full screen pass, so keep them bounded
   localparam int SWEEP_CAP     = 90;
   localparam int PHASE_ITEMS   = 32;
   localparam int PHASE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 40;
   localparam int IDLE_PCT      = 34;

   // the block only decodes 0..2, this one must leave everything alone
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]      op;
      logic [BYTE_W-1:0]    ch;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
   } request_type;

   typedef enum int {
      SEQ_TEXT,
      SEQ_LINE_END,
      SEQ_READS,
      SEQ_FULL_LINE,
      SEQ_TO_BOTTOM,
      SEQ_CLEAR,
      SEQ_NOP,
      SEQ_OVERWRITE
   } seq_kind_type;

   // dut ports, every input known from time zero
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation  = '0;
   logic [BYTE_W-1:0]    req_char_code  = '0;
   logic [ROW_OUT_W-1:0] req_read_row   = '0;
   logic [COL_OUT_W-1:0] req_read_col   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]    rsp_cell_char;
   logic [BYTE_W-1:0]    rsp_cell_attr;
   logic [ROW_OUT_W-1:0] rsp_cursor_row;
   logic [COL_OUT_W-1:0] rsp_cursor_col;
   logic                 csr_wr_en      = 1'b0;
   logic [BYTE_W-1:0]    csr_wr_data    = '0;

   // console model state: screen, cursor and attribute register
   logic [CELL_W-1:0] screen_model [CELL_COUNT];
   int                cur_row = 0;
   int                cur_col = 0;
   logic [BYTE_W-1:0] attr_model = ATTR_DEFAULT;

   // transaction stores
   request_type       pending_requests [$];
   res_type           expected_results [$];

   // stimulus-side cursor shadow, used to aim reads and to count sweeps
   int gen_row     = 0;
   int gen_col     = 0;
   int sweep_count = 0;
   int phase_items = 0;

   // bookkeeping
   int  cycle_count     = 0;
   int  sent_count      = 0;
   int  results_checked = 0;
   int  error_count     = 0;
   int  attr_writes     = 0;
   int  send_idle_pct   = IDLE_PCT;
   int  recv_stall_pct  = IDLE_PCT;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  req_taken       = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_console_writer_top #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // screen comes out of reset blank in the default attribute
   initial begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_model[i] = BLANK_DEFAULT;
      end
   end

   // cursor movement of one transaction; shared by the model and the stimulus shadow
   function automatic void cursor_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] ch,
                                       inout int row, inout int col,
                                       output bit wrote, output bit shifted);
      wrote   = 1'b0;
      shifted = 1'b0;
      if (op == OP_CLEAR) begin
         row = 0;
         col = 0;
      end else if (op == OP_PUT) begin
         if (ch == CH_RETURN) begin
            col = 0;
         end else begin
            wrote = (ch != CH_NEWLINE);
            // newline, or a printable byte in the last column, moves to the next line
            if (ch == CH_NEWLINE || col == COLS - 1) begin
               if (row == ROWS - 1) begin
                  shifted = 1'b1;
               end else begin
                  row++;
               end
               col = 0;
            end else begin
               col++;
            end
         end
      end
   endfunction

   // applies one accepted transaction to the console model and returns its result
   function automatic res_type console_step(input request_type rq);
      res_type rs;
      int      old_row;
      int      old_col;
      bit      wrote;
      bit      shifted;
      rs      = '0;
      old_row = cur_row;
      old_col = cur_col;
      cursor_step(rq.op, rq.ch, cur_row, cur_col, wrote, shifted);
      if (wrote) begin
         screen_model[old_row * COLS + old_col] = {attr_model, rq.ch};
      end
      // scroll: rows move up, the new bottom row is blank in the default attribute
      if (shifted) begin
         for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = (i < CELL_COUNT - COLS) ? screen_model[i + COLS] : BLANK_DEFAULT;
         end
      end
      // clear uses the current attribute, not the default
      if (rq.op == OP_CLEAR) begin
         for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = {attr_model, CH_SPACE};
         end
      end
      // out-of-range reads return zero cell fields
      if (rq.op == OP_READ && rq.row < ROWS && rq.col < COLS) begin
         {rs.cell_attr, rs.cell_char} = screen_model[rq.row * COLS + rq.col];
      end
      rs.cursor_row = ROW_OUT_W'(cur_row);
      rs.cursor_col = COL_OUT_W'(cur_col);
      return rs;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t mismatch on %s: expected 'h%0h, actual 'h%0h", $time, name, want, got);
         end
      end
   endtask

   // queue one transaction; a sweep past the budget is turned into a carriage return
   task automatic push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] ch,
                            input logic [ROW_OUT_W-1:0] rr, input logic [COL_OUT_W-1:0] rc);
      request_type rq;
      int          r;
      int          c;
      bit          wrote;
      bit          shifted;
      r = gen_row;
      c = gen_col;
      cursor_step(op, ch, r, c, wrote, shifted);
      if ((shifted || op == OP_CLEAR) && sweep_count >= SWEEP_CAP) begin
         op = OP_PUT;
         ch = CH_RETURN;
         r  = gen_row;
         c  = gen_col;
         cursor_step(op, ch, r, c, wrote, shifted);
      end
      if (shifted || op == OP_CLEAR) begin
         sweep_count++;
      end
      gen_row = r;
      gen_col = c;
      rq.op   = op;
      rq.ch   = ch;
      rq.row  = rr;
      rq.col  = rc;
      pending_requests.push_back(rq);
      phase_items++;
   endtask

   // put with don't-care read coordinates, randomized so their bits toggle
   task automatic put_char(input logic [BYTE_W-1:0] ch);
      push_item(OP_PUT, ch, ROW_OUT_W'($urandom_range(0, 31)),
                COL_OUT_W'($urandom_range(0, 127)));
   endtask

   task automatic run_sequence(input seq_kind_type kind);
      int                   n;
      int                   sel;
      logic [ROW_OUT_W-1:0] rr;
      logic [COL_OUT_W-1:0] rc;
      case (kind)
         SEQ_TEXT: begin
            n = $urandom_range(1, 16);
            repeat (n) put_char(BYTE_W'($urandom_range(0, 255)));
         end
         SEQ_LINE_END: begin
            sel = $urandom_range(0, 2);
            if (sel != 1) put_char(CH_RETURN);
            if (sel != 0) put_char(CH_NEWLINE);
         end
         SEQ_READS: begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               sel = $urandom_range(0, 9);
               if (sel < 5) begin
                  // aim at text just written: current line or the one above
                  if (gen_row > 0 && sel == 0) begin
                     rr = ROW_OUT_W'(gen_row - 1);
                     rc = COL_OUT_W'($urandom_range(0, COLS - 1));
                  end else begin
                     rr = ROW_OUT_W'(gen_row);
                     rc = COL_OUT_W'($urandom_range(0, gen_col));
                  end
               end else if (sel < 8) begin
                  rr = ROW_OUT_W'($urandom_range(0, ROWS - 1));
                  rc = COL_OUT_W'($urandom_range(0, COLS - 1));
               end else if (sel == 8) begin
                  rr = ROW_OUT_W'($urandom_range(ROWS, 31));
                  rc = COL_OUT_W'($urandom_range(0, 127));
               end else begin
                  rr = ROW_OUT_W'($urandom_range(0, 31));
                  rc = COL_OUT_W'($urandom_range(COLS, 127));
               end
               push_item(OP_READ, BYTE_W'($urandom_range(0, 255)), rr, rc);
            end
         end
         SEQ_FULL_LINE: begin
            // runs past the end of the line, so the wrap (or bottom-right scroll) happens
            n = COLS - gen_col + $urandom_range(0, 5);
            repeat (n) put_char(BYTE_W'($urandom_range(33, 126)));
         end
         SEQ_TO_BOTTOM: begin
            while (gen_row < ROWS - 1) put_char(CH_NEWLINE);
            n = $urandom_range(1, 8);
            repeat (n) put_char(BYTE_W'($urandom_range(0, 255)));
         end
         SEQ_CLEAR: begin
            push_item(OP_CLEAR, BYTE_W'($urandom_range(0, 255)),
                      ROW_OUT_W'($urandom_range(0, 31)), COL_OUT_W'($urandom_range(0, 127)));
         end
         SEQ_NOP: begin
            push_item(OP_UNUSED, BYTE_W'($urandom_range(0, 255)),
                      ROW_OUT_W'($urandom_range(0, 31)), COL_OUT_W'($urandom_range(0, 127)));
         end
         default: begin
            // return to column 0 and overwrite what is there
            put_char(CH_RETURN);
            n = $urandom_range(1, 6);
            repeat (n) put_char(BYTE_W'($urandom_range(0, 255)));
            push_item(OP_READ, 8'h00, ROW_OUT_W'(gen_row), '0);
         end
      endcase
   endtask

   function automatic seq_kind_type pick_kind();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 33) return SEQ_TEXT;
      if (pick < 43) return SEQ_LINE_END;
      if (pick < 68) return SEQ_READS;
      if (pick < 75) return SEQ_FULL_LINE;
      if (pick < 81) return SEQ_TO_BOTTOM;
      if (pick < 85) return SEQ_CLEAR;
      if (pick < 89) return SEQ_NOP;
      return SEQ_OVERWRITE;
   endfunction

   // waits until every queued transaction has been answered and the block has settled
   task automatic wait_for_drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      attr_writes++;
   endtask

   // request driver: a new transaction only once the current one is taken
   always @(negedge clock) begin
      request_type next_req;
      if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_req.op;
            req_char_code <= next_req.ch;
            req_read_row  <= next_req.row;
            req_read_col  <= next_req.col;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random, plus one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // rising-edge monitor: register writes, result checks, request predictions
   always @(posedge clock) begin
      res_type     want;
      request_type seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t cycle limit hit, %0d results outstanding", $time,
                  expected_results.size());
         $display("tb: failure");
         $finish;
      end
      if (!reset) begin
         if (csr_wr_en) begin
            attr_model = csr_wr_data;
         end
         // result side: compare against the oldest prediction first
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t unexpected result: expected none, actual char 'h%0h attr 'h%0h",
                        $time, rsp_cell_char, rsp_cell_attr);
               $display("   cursor row %0d col %0d", rsp_cursor_row, rsp_cursor_col);
            end else begin
               want = expected_results.pop_front();
               check_field("cell_char", want.cell_char, rsp_cell_char);
               check_field("cell_attr", want.cell_attr, rsp_cell_attr);
               check_field("cursor_row", 8'(want.cursor_row), 8'(rsp_cursor_row));
               check_field("cursor_col", 8'(want.cursor_col), 8'(rsp_cursor_col));
            end
            results_checked++;
         end
         // request side: predict the result of each accepted transaction
         if (req_valid && req_stall === 1'b0) begin
            seen.op  = req_operation;
            seen.ch  = req_char_code;
            seen.row = req_read_row;
            seen.col = req_read_col;
            expected_results.push_back(console_step(seen));
            sent_count++;
         end
      end
      req_taken <= req_valid && (req_stall === 1'b0) && !reset;
   end

   initial begin
      logic [BYTE_W-1:0] attr_plan [PHASE_COUNT];
      attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h80, ATTR_DEFAULT, 8'h00, 8'h01, 8'h00};
      attr_plan[2] = BYTE_W'($urandom_range(0, 255));
      attr_plan[5] = BYTE_W'($urandom_range(0, 255));
      attr_plan[7] = BYTE_W'($urandom_range(0, 255));

      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: fresh screen, range edges, unused op, byte extremes, cr, lf, clear
      push_item(OP_READ, 8'h00, '0, '0);
      push_item(OP_READ, 8'hFF, ROW_OUT_W'(ROWS - 1), COL_OUT_W'(COLS - 1));
      push_item(OP_READ, 8'h00, ROW_OUT_W'(ROWS), '0);
      push_item(OP_READ, 8'h00, '0, COL_OUT_W'(COLS));
      push_item(OP_READ, 8'hFF, 5'h1F, 7'h7F);
      push_item(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
      push_item(OP_UNUSED, 8'h00, '0, '0);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h41);
      put_char(CH_RETURN);
      put_char(8'h7E);
      put_char(CH_NEWLINE);
      put_char(8'h80);
      push_item(OP_READ, 8'h00, '0, '0);
      push_item(OP_READ, 8'h00, '0, 7'd1);
      push_item(OP_READ, 8'h00, '0, 7'd2);
      push_item(OP_READ, 8'h00, 5'd1, '0);
      push_item(OP_CLEAR, 8'h55, 5'h0A, 7'h55);
      push_item(OP_READ, 8'h00, '0, '0);
      push_item(OP_READ, 8'h00, 5'd1, '0);
      wait_for_drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_attribute(attr_plan[ph]);
         // one phase runs back to back on both sides
         send_idle_pct  = (ph == 3) ? 0 : IDLE_PCT;
         recv_stall_pct = (ph == 3) ? 0 : IDLE_PCT;
         phase_items    = 0;
         if (ph == 0) begin
            // newline on the last row, then a line that ends in the bottom-right cell
            run_sequence(SEQ_TO_BOTTOM);
            put_char(CH_NEWLINE);
            run_sequence(SEQ_FULL_LINE);
            push_item(OP_READ, 8'h00, ROW_OUT_W'(ROWS - 2), '0);
            push_item(OP_READ, 8'h00, ROW_OUT_W'(ROWS - 2), COL_OUT_W'(COLS - 1));
            push_item(OP_READ, 8'h00, ROW_OUT_W'(ROWS - 1), '0);
            push_item(OP_READ, 8'h00, ROW_OUT_W'(ROWS - 1), COL_OUT_W'(COLS - 1));
         end
         while (phase_items < PHASE_ITEMS) run_sequence(pick_kind());
         // sender pauses here until every result is back
         wait_for_drain();
      end

      $display("tb: %0d transactions sent, %0d results checked, %0d attribute settings",
               sent_count, results_checked, attr_writes);
      $display("tb: %0d scrolls or clears issued, %0d mismatches", sweep_count, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_engine.sv
rtl/text_console_writer_top.sv
bench/tb.sv
